// ===== design/fcgi_pkg.sv =====
// shared types and constants of the fastcgi record deframer
// used by the top level, the result queue and the checker; no dependencies
`default_nettype none

package fcgi_pkg;

   // result event codes
   localparam logic [3:0] EV_NAME       = 4'd0;
   localparam logic [3:0] EV_VALUE      = 4'd1;
   localparam logic [3:0] EV_PAIR       = 4'd2;
   localparam logic [3:0] EV_PARAMS_OK  = 4'd3;
   localparam logic [3:0] EV_PARAMS_ERR = 4'd4;
   localparam logic [3:0] EV_STDIN      = 4'd5;
   localparam logic [3:0] EV_STDIN_DONE = 4'd6;
   localparam logic [3:0] EV_BEGIN_OK   = 4'd7;
   localparam logic [3:0] EV_BEGIN_REJ  = 4'd8;

   // record types and begin record fields
   localparam logic [7:0]  TYPE_BEGIN     = 8'd1;
   localparam logic [7:0]  TYPE_PARAMS    = 8'd4;
   localparam logic [7:0]  TYPE_STDIN     = 8'd5;
   localparam logic [15:0] ROLE_RESPONDER = 16'd1;
   localparam logic [7:0]  KEEP_CONN      = 8'd1;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // one result item
   typedef struct packed {
      logic [3:0] event_res;
      logic [7:0] payload;
      logic       keep_connection;
      logic       last_of_run;
   } rsp_item_type;

   // results produced by one input item, pushed in one cycle
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

endpackage

`default_nettype wire

// ===== design/fastcgi_record_deframer_unit.sv =====
// fastcgi record deframer top level: record, begin and params parsing
// depends on fcgi_pkg and fcgi_rsp_queue
//
// usage:
//   req channel carries one raw stream byte per item (req_data_byte).
//   rsp channel carries result items: event code, payload byte, current
//   keep-connection flag and a last-of-run mark on the final result of a byte.
//   a byte causes zero, one or two results.
//   latency: results of a byte accepted at one edge are offered from the
//   next cycle on.
//   throughput: one byte per cycle while req_ready is high; the header, record
//   and pair parsers update in the accept cycle, and the results go into a four-entry
//   queue that drains one result per cycle, so a run of bytes that each
//   cause two results is held to one result per cycle.
//   req_ready is high while the queue has at least two free entries.
//   when the receiver stalls, results wait in the queue and bytes keep
//   being taken until it runs short of room.
//   reset (synchronous, active high) empties the queue and returns all
//   parsers to the start of a record header.
`default_nettype none

module fastcgi_record_deframer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_event_res,
   output logic [7:0]      rsp_payload,
   output logic            rsp_keep_connection,
   output logic            rsp_last_of_run
);

   // record phase codes
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_CONTENT = 2'd1;
   localparam logic [1:0] PH_PADDING = 2'd2;

   // pair parser phase codes
   localparam logic [2:0] PP_NAME_LEN      = 3'd0;
   localparam logic [2:0] PP_NAME_LEN_MORE = 3'd1;
   localparam logic [2:0] PP_VAL_LEN       = 3'd2;
   localparam logic [2:0] PP_VAL_LEN_MORE  = 3'd3;
   localparam logic [2:0] PP_NAME_DATA     = 3'd4;
   localparam logic [2:0] PP_VALUE_DATA    = 3'd5;

   logic [1:0]  record_phase_ff, record_phase_in;
   logic [2:0]  header_index_ff, header_index_in;
   logic [7:0]  record_type_ff, record_type_in;
   logic [15:0] content_left_ff, content_left_in;
   logic [7:0]  padding_left_ff, padding_left_in;
   logic [2:0]  content_index_ff, content_index_in;
   logic [15:0] role_word_ff, role_word_in;
   logic [7:0]  begin_flags_ff, begin_flags_in;
   logic [2:0]  pair_phase_ff, pair_phase_in;
   logic [1:0]  len_seen_ff, len_seen_in;
   logic [30:0] len_shift_ff, len_shift_in;
   logic [30:0] value_length_ff, value_length_in;
   logic [30:0] pair_left_ff, pair_left_in;
   logic        keep_conn_ff, keep_conn_in;

   logic                   accept;
   logic                   room_two;
   logic                   last_content;
   logic                   len_fire;
   logic [30:0]            len_val;
   logic [1:0]             res_count;
   logic [3:0]             ev_res  [2];
   logic [7:0]             pay_res [2];
   fcgi_pkg::rsp_push_type push;
   fcgi_pkg::rsp_item_type head;

   assign req_ready    = room_two;
   assign accept       = req_valid && req_ready;
   assign last_content = content_left_ff == 16'd1;

   // per-byte parse: next state and the results this byte causes
   always_comb begin
      record_phase_in  = record_phase_ff;
      header_index_in  = header_index_ff;
      record_type_in   = record_type_ff;
      content_left_in  = content_left_ff;
      padding_left_in  = padding_left_ff;
      content_index_in = content_index_ff;
      role_word_in     = role_word_ff;
      begin_flags_in   = begin_flags_ff;
      pair_phase_in    = pair_phase_ff;
      len_seen_in      = len_seen_ff;
      len_shift_in     = len_shift_ff;
      value_length_in  = value_length_ff;
      pair_left_in     = pair_left_ff;
      keep_conn_in     = keep_conn_ff;
      len_fire         = 1'b0;
      len_val          = '0;
      res_count        = 2'd0;
      ev_res[0]        = fcgi_pkg::EV_PAIR;
      ev_res[1]        = fcgi_pkg::EV_PAIR;
      pay_res[0]       = 8'd0;
      pay_res[1]       = 8'd0;

      if (record_phase_ff == PH_CONTENT) begin
         // content byte
         if (record_type_ff == fcgi_pkg::TYPE_BEGIN) begin
            case (content_index_ff)
               3'd0:    role_word_in = {req_data_byte, 8'd0};
               3'd1:    role_word_in = role_word_ff | {8'd0, req_data_byte};
               3'd2:    begin_flags_in = req_data_byte;
               default: ;
            endcase
            if (last_content) begin
               if (content_index_ff == 3'd7 &&
                   role_word_in == fcgi_pkg::ROLE_RESPONDER) begin
                  keep_conn_in = begin_flags_in == fcgi_pkg::KEEP_CONN;
                  ev_res[res_count[0]] = fcgi_pkg::EV_BEGIN_OK;
               end else begin
                  ev_res[res_count[0]] = fcgi_pkg::EV_BEGIN_REJ;
               end
               res_count = res_count + 2'd1;
            end
         end else if (record_type_ff == fcgi_pkg::TYPE_PARAMS) begin
            // name-value pair parser
            unique case (pair_phase_ff)
               PP_NAME_LEN, PP_VAL_LEN: begin
                  if (req_data_byte[7]) begin
                     len_shift_in  = {24'd0, req_data_byte[6:0]};
                     len_seen_in   = 2'd0;
                     pair_phase_in = pair_phase_ff + 3'd1;
                  end else begin
                     len_fire = 1'b1;
                     len_val  = {23'd0, req_data_byte};
                  end
               end
               PP_NAME_LEN_MORE, PP_VAL_LEN_MORE: begin
                  len_shift_in = {len_shift_ff[22:0], req_data_byte};
                  len_seen_in  = len_seen_ff + 2'd1;
                  if (len_seen_ff == 2'd2) begin
                     len_fire = 1'b1;
                     len_val  = len_shift_in;
                  end
               end
               PP_NAME_DATA: begin
                  ev_res[res_count[0]]  = fcgi_pkg::EV_NAME;
                  pay_res[res_count[0]] = req_data_byte;
                  res_count             = res_count + 2'd1;
                  pair_left_in          = pair_left_ff - 31'd1;
                  if (pair_left_in == '0) begin
                     if (value_length_ff != '0) begin
                        pair_left_in  = value_length_ff;
                        pair_phase_in = PP_VALUE_DATA;
                     end else begin
                        pair_phase_in        = PP_NAME_LEN;
                        ev_res[res_count[0]] = fcgi_pkg::EV_PAIR;
                        res_count            = res_count + 2'd1;
                     end
                  end
               end
               PP_VALUE_DATA: begin
                  ev_res[res_count[0]]  = fcgi_pkg::EV_VALUE;
                  pay_res[res_count[0]] = req_data_byte;
                  res_count             = res_count + 2'd1;
                  pair_left_in          = pair_left_ff - 31'd1;
                  if (pair_left_in == '0) begin
                     pair_phase_in        = PP_NAME_LEN;
                     ev_res[res_count[0]] = fcgi_pkg::EV_PAIR;
                     res_count            = res_count + 2'd1;
                  end
               end
               default: pair_phase_in = PP_NAME_LEN;
            endcase

            // a length field is complete
            if (len_fire) begin
               if (pair_phase_ff == PP_NAME_LEN || pair_phase_ff == PP_NAME_LEN_MORE) begin
                  pair_left_in  = len_val;
                  pair_phase_in = PP_VAL_LEN;
               end else begin
                  value_length_in = len_val;
                  if (pair_left_ff != '0) begin
                     pair_phase_in = PP_NAME_DATA;
                  end else if (len_val != '0) begin
                     pair_left_in  = len_val;
                     pair_phase_in = PP_VALUE_DATA;
                  end else begin
                     pair_phase_in        = PP_NAME_LEN;
                     ev_res[res_count[0]] = fcgi_pkg::EV_PAIR;
                     res_count            = res_count + 2'd1;
                  end
               end
            end
         end else if (record_type_ff == fcgi_pkg::TYPE_STDIN) begin
            ev_res[res_count[0]]  = fcgi_pkg::EV_STDIN;
            pay_res[res_count[0]] = req_data_byte;
            res_count             = res_count + 2'd1;
         end
         if (content_index_ff != 3'd7) begin
            content_index_in = content_index_ff + 3'd1;
         end
         content_left_in = content_left_ff - 16'd1;
         if (last_content) begin
            record_phase_in = (padding_left_ff != '0) ? PH_PADDING : PH_HEADER;
         end
      end else if (record_phase_ff == PH_PADDING) begin
         // padding byte
         padding_left_in = padding_left_ff - 8'd1;
         if (padding_left_in == '0) begin
            record_phase_in = PH_HEADER;
         end
      end else begin
         // header byte; the unused phase code acts as header
         case (header_index_ff)
            3'd0: begin
               content_index_in = '0;
               role_word_in     = '0;
               begin_flags_in   = '0;
            end
            3'd1:    record_type_in  = req_data_byte;
            3'd4:    content_left_in = {req_data_byte, 8'd0};
            3'd5:    content_left_in = content_left_ff | {8'd0, req_data_byte};
            3'd6:    padding_left_in = req_data_byte;
            default: ;
         endcase
         if (header_index_ff != 3'd7) begin
            header_index_in = header_index_ff + 3'd1;
            record_phase_in = PH_HEADER;
         end else begin
            header_index_in = '0;
            if (content_left_ff != '0) begin
               record_phase_in = PH_CONTENT;
            end else begin
               // empty record
               if (record_type_ff == fcgi_pkg::TYPE_BEGIN) begin
                  ev_res[0] = fcgi_pkg::EV_BEGIN_REJ;
                  res_count = 2'd1;
               end else if (record_type_ff == fcgi_pkg::TYPE_PARAMS) begin
                  ev_res[0] = (pair_phase_ff == PP_NAME_LEN) ? fcgi_pkg::EV_PARAMS_OK
                                                             : fcgi_pkg::EV_PARAMS_ERR;
                  res_count       = 2'd1;
                  pair_phase_in   = PP_NAME_LEN;
                  len_seen_in     = '0;
                  len_shift_in    = '0;
                  value_length_in = '0;
                  pair_left_in    = '0;
               end else if (record_type_ff == fcgi_pkg::TYPE_STDIN) begin
                  ev_res[0] = fcgi_pkg::EV_STDIN_DONE;
                  res_count = 2'd1;
               end
               record_phase_in = (padding_left_ff != '0) ? PH_PADDING : PH_HEADER;
            end
         end
      end
   end

   // results toward the queue
   always_comb begin
      push.count                  = accept ? res_count : 2'd0;
      push.first.event_res        = ev_res[0];
      push.first.payload          = pay_res[0];
      push.first.keep_connection  = keep_conn_in;
      push.first.last_of_run      = res_count == 2'd1;
      push.second.event_res       = ev_res[1];
      push.second.payload         = pay_res[1];
      push.second.keep_connection = keep_conn_in;
      push.second.last_of_run     = 1'b1;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         record_phase_ff  <= PH_HEADER;
         header_index_ff  <= '0;
         record_type_ff   <= '0;
         content_left_ff  <= '0;
         padding_left_ff  <= '0;
         content_index_ff <= '0;
         role_word_ff     <= '0;
         begin_flags_ff   <= '0;
         pair_phase_ff    <= PP_NAME_LEN;
         len_seen_ff      <= '0;
         len_shift_ff     <= '0;
         value_length_ff  <= '0;
         pair_left_ff     <= '0;
         keep_conn_ff     <= 1'b0;
      end else if (accept) begin
         record_phase_ff  <= record_phase_in;
         header_index_ff  <= header_index_in;
         record_type_ff   <= record_type_in;
         content_left_ff  <= content_left_in;
         padding_left_ff  <= padding_left_in;
         content_index_ff <= content_index_in;
         role_word_ff     <= role_word_in;
         begin_flags_ff   <= begin_flags_in;
         pair_phase_ff    <= pair_phase_in;
         len_seen_ff      <= len_seen_in;
         len_shift_ff     <= len_shift_in;
         value_length_ff  <= value_length_in;
         pair_left_ff     <= pair_left_in;
         keep_conn_ff     <= keep_conn_in;
      end
   end

   // result queue
   fcgi_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (head)
   );

   assign rsp_event_res       = head.event_res;
   assign rsp_payload         = head.payload;
   assign rsp_keep_connection = head.keep_connection;
   assign rsp_last_of_run     = head.last_of_run;

endmodule

`default_nettype wire

// ===== design/fcgi_rsp_queue.sv =====
// four-entry result queue: takes up to two items per cycle, hands out one
// depends on fcgi_pkg
`default_nettype none

module fcgi_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fcgi_pkg::rsp_push_type push,
   output logic                       room_two,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output fcgi_pkg::rsp_item_type     rsp_item
);

   fcgi_pkg::rsp_item_type entry_ff [fcgi_pkg::QUEUE_DEPTH];
   logic [fcgi_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fcgi_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fcgi_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [fcgi_pkg::QPTR_W-1:0] wr_next;
   logic                        pop;

   // status toward both sides
   assign room_two  = count_ff <= fcgi_pkg::QCNT_W'(fcgi_pkg::QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ptr_ff + fcgi_pkg::QPTR_W'(1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + fcgi_pkg::QPTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + fcgi_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + fcgi_pkg::QCNT_W'(push.count) - fcgi_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ===== design/fcgi_checker.sv =====
// port-level checks of the fastcgi record deframer, bound to the top level
// depends on fcgi_pkg and fastcgi_record_deframer_unit
`default_nettype none

module fcgi_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_event_res,
   input wire logic [7:0] rsp_payload,
   input wire logic       rsp_last_of_run
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // the partner of a first-of-two result is already queued
   a_run_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("run of results broken");

   // only byte-carrying events carry a payload
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != fcgi_pkg::EV_NAME &&
      rsp_event_res != fcgi_pkg::EV_VALUE && rsp_event_res != fcgi_pkg::EV_STDIN
      |-> rsp_payload == 8'd0)
      else $error("payload on a non-byte event");

   // a first-of-two result is always a name or value byte
   a_first_is_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |->
      (rsp_event_res == fcgi_pkg::EV_NAME || rsp_event_res == fcgi_pkg::EV_VALUE))
      else $error("unexpected first result of a run");

endmodule

bind fastcgi_record_deframer_unit fcgi_checker u_fcgi_checker (.*);

`default_nettype wire
